// ----- rtl/event_feature_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// Event feature accumulator assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EVENT_FEATURE_ACCUMULATOR_ASSERT_SVH
`define EVENT_FEATURE_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event feature accumulator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event feature accumulator: next-cycle check failed");

`endif

// ----- rtl/efa_pkg.sv -----
// ----------------------------------------------------------------------------
// Event feature accumulator package
// Beat types, register indexes, widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package efa_pkg;

    localparam int COUNT_WIDTH_DEF = 12;
    localparam int SUM_WIDTH_DEF   = 32;

    localparam int MOM_W     = 20;
    localparam int MAG_W     = 20;
    localparam int ENERGY_W  = 20;
    localparam int IMPACT_W  = 12;
    localparam int TANH_W    = 16;
    localparam int PT_W      = 20;
    localparam int COUNT_OUT_W = 12;
    localparam int SUM_OUT_W   = 32;
    localparam int CLASS_W   = 2;

    // Square of one magnitude, sum of two squares, sum of three squares.
    localparam int SQ_W   = 2 * MAG_W - 1;
    localparam int PT2_W  = 2 * MAG_W;
    localparam int P2_W   = 2 * MAG_W;
    localparam int PROD_W = TANH_W + P2_W;

    // Bit-serial square root: one result bit per step.
    localparam int SQRT_STEPS = PT2_W / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 3;
    localparam int STEP_CNT_W = $clog2(SQRT_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRAL_TANH_SQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_TANH_SQ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_PT_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_PT_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_PT_MAX     = 3'd4;

    localparam logic [TANH_W-1:0] CENTRAL_TANH_SQ_RST = 16'd62778;
    localparam logic [TANH_W-1:0] FORWARD_TANH_SQ_RST = 16'd65298;
    localparam logic [PT_W-1:0]   SOFT_PT_MAX_RST     = 20'd819;
    localparam logic [PT_W-1:0]   HARD_PT_MIN_RST     = 20'd1638;
    localparam logic [PT_W-1:0]   HARD_PT_MAX_RST     = 20'd2458;

    typedef struct packed {
        logic signed [MOM_W-1:0] mom_x;
        logic signed [MOM_W-1:0] mom_y;
        logic signed [MOM_W-1:0] mom_z;
        logic [ENERGY_W-1:0]     particle_energy;
        logic                    is_charged;
        logic [IMPACT_W-1:0]     impact_param;
        logic                    last_of_event;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] multiplicity;
        logic [SUM_OUT_W-1:0]   sum_pt;
        logic [SUM_OUT_W-1:0]   spectator_energy;
        logic [COUNT_OUT_W-1:0] soft_count;
        logic [COUNT_OUT_W-1:0] hard_count;
        logic [CLASS_W-1:0]     impact_class;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic sq_x;
        logic sq_y;
        logic sq_z;
        logic sum;
        logic cmul;
        logic fmul;
        logic root_step;
        logic accum;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_full;
    } dp_status_t;

endpackage

// ----- rtl/efa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Event feature accumulator controller
// Sequences the squaring, cut products, square root and accumulation steps.
// ----------------------------------------------------------------------------
module efa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  efa_pkg::dp_status_t    status,
    output efa_pkg::dp_cmd_t       cmd
);
    import efa_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQX  = 9'b000000010,
        ST_SQY  = 9'b000000100,
        ST_SQZ  = 9'b000001000,
        ST_SUM  = 9'b000010000,
        ST_CMUL = 9'b000100000,
        ST_FMUL = 9'b001000000,
        ST_ROOT = 9'b010000000,
        ST_ACC  = 9'b100000000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [STEP_CNT_W-1:0] cnt_next;
    logic                  stall;

    // A closing particle waits while the previous row is still held.
    assign stall    = status.last && status.out_full;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = ST_SQZ;
            end
            ST_SQZ:
            begin
                cmd.sq_z   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                cnt_next   = STEP_CNT_W'(SQRT_STEPS - 1);
                state_next = ST_CMUL;
            end
            ST_CMUL:
            begin
                cmd.cmul   = 1'b1;
                state_next = ST_FMUL;
            end
            ST_FMUL:
            begin
                cmd.fmul   = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg - STEP_CNT_W'(1);
                end
            end
            ST_ACC:
            begin
                if (!stall)
                begin
                    cmd.accum  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/efa_datapath.sv -----
// ----------------------------------------------------------------------------
// Event feature accumulator datapath
// Squares, cut products, bit-serial square root, accumulators and row register.
// ----------------------------------------------------------------------------
module efa_datapath #(
    parameter int COUNT_WIDTH = efa_pkg::COUNT_WIDTH_DEF,
    parameter int SUM_WIDTH   = efa_pkg::SUM_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  efa_pkg::in_item_t               in_data,
    input  efa_pkg::dp_cmd_t                cmd,
    output efa_pkg::dp_status_t             status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output efa_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [efa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [efa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import efa_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = '1;

    // Configuration
    logic [TANH_W-1:0] central_tanh_sq_reg;
    logic [TANH_W-1:0] forward_tanh_sq_reg;
    logic [PT_W-1:0]   soft_pt_max_reg;
    logic [PT_W-1:0]   hard_pt_min_reg;
    logic [PT_W-1:0]   hard_pt_max_reg;

    // Particle held for the duration of its work
    logic [MAG_W-1:0]    mag_x_reg;
    logic [MAG_W-1:0]    mag_y_reg;
    logic [MAG_W-1:0]    mag_z_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic                charged_reg;
    logic [IMPACT_W-1:0] impact_reg;
    logic                last_reg;

    // Intermediate results
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   pz2_reg;
    logic [PT2_W-1:0]  pt2_reg;
    logic [P2_W-1:0]   p2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              central_reg;
    logic              forward_reg;
    logic [PT2_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    // Accumulators
    logic [COUNT_WIDTH-1:0] mult_acc_reg;
    logic [COUNT_WIDTH-1:0] mult_acc_next;
    logic [SUM_WIDTH-1:0]   pt_acc_reg;
    logic [SUM_WIDTH-1:0]   pt_acc_next;
    logic [SUM_WIDTH-1:0]   energy_acc_reg;
    logic [SUM_WIDTH-1:0]   energy_acc_next;
    logic [COUNT_WIDTH-1:0] soft_acc_reg;
    logic [COUNT_WIDTH-1:0] soft_acc_next;
    logic [COUNT_WIDTH-1:0] hard_acc_reg;
    logic [COUNT_WIDTH-1:0] hard_acc_next;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    logic [MAG_W-1:0]       mag_x;
    logic [MAG_W-1:0]       mag_y;
    logic [MAG_W-1:0]       mag_z;
    logic [MAG_W-1:0]       mul_a;
    logic [PT2_W-1:0]       sq_full;
    logic [SQ_W-1:0]        sq;
    logic [TANH_W-1:0]      tanh_sel;
    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      lhs;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic                   take;
    logic                   is_soft;
    logic                   is_hard;
    logic [COUNT_WIDTH-1:0] mult_upd;
    logic [COUNT_WIDTH-1:0] soft_upd;
    logic [COUNT_WIDTH-1:0] hard_upd;
    logic [SUM_WIDTH:0]     pt_sum;
    logic [SUM_WIDTH:0]     energy_sum;
    logic [SUM_WIDTH-1:0]   pt_upd;
    logic [SUM_WIDTH-1:0]   energy_upd;
    logic                   load_out;

    // Two's complement magnitude; the most negative value maps to 2^19.
    assign mag_x = in_data.mom_x[MOM_W-1] ? MAG_W'(-in_data.mom_x) : MAG_W'(in_data.mom_x);
    assign mag_y = in_data.mom_y[MOM_W-1] ? MAG_W'(-in_data.mom_y) : MAG_W'(in_data.mom_y);
    assign mag_z = in_data.mom_z[MOM_W-1] ? MAG_W'(-in_data.mom_z) : MAG_W'(in_data.mom_z);

    // Shared squaring multiplier.
    assign mul_a   = cmd.sq_x ? mag_x_reg : (cmd.sq_y ? mag_y_reg : mag_z_reg);
    assign sq_full = PT2_W'(mul_a) * PT2_W'(mul_a);
    assign sq      = sq_full[SQ_W-1:0];

    // Shared cut multiplier: tanh^2 limit times |p|^2.
    assign tanh_sel = cmd.cmul ? central_tanh_sq_reg : forward_tanh_sq_reg;
    assign prod     = PROD_W'(tanh_sel) * PROD_W'(p2_reg);
    assign lhs      = PROD_W'(pz2_reg) << TANH_W;

    // One restoring square root step consumes two radicand bits.
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[PT2_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});

    assign take    = charged_reg && central_reg;
    assign is_soft = root_reg < soft_pt_max_reg;
    assign is_hard = (root_reg > hard_pt_min_reg) && (root_reg < hard_pt_max_reg);

    assign pt_sum     = {1'b0, pt_acc_reg} + (SUM_WIDTH + 1)'(root_reg);
    assign energy_sum = {1'b0, energy_acc_reg} + (SUM_WIDTH + 1)'(energy_reg);

    always_comb
    begin
        mult_upd   = mult_acc_reg;
        soft_upd   = soft_acc_reg;
        hard_upd   = hard_acc_reg;
        pt_upd     = pt_acc_reg;
        energy_upd = energy_acc_reg;
        if (take)
        begin
            if (mult_acc_reg != COUNT_MAX)
            begin
                mult_upd = mult_acc_reg + COUNT_WIDTH'(1);
            end
            pt_upd = pt_sum[SUM_WIDTH] ? SUM_MAX : pt_sum[SUM_WIDTH-1:0];
            if (is_soft && (soft_acc_reg != COUNT_MAX))
            begin
                soft_upd = soft_acc_reg + COUNT_WIDTH'(1);
            end
            if (is_hard && (hard_acc_reg != COUNT_MAX))
            begin
                hard_upd = hard_acc_reg + COUNT_WIDTH'(1);
            end
        end
        if (forward_reg)
        begin
            energy_upd = energy_sum[SUM_WIDTH] ? SUM_MAX : energy_sum[SUM_WIDTH-1:0];
        end
    end

    assign load_out = cmd.accum && last_reg;

    always_comb
    begin
        mult_acc_next   = mult_acc_reg;
        pt_acc_next     = pt_acc_reg;
        energy_acc_next = energy_acc_reg;
        soft_acc_next   = soft_acc_reg;
        hard_acc_next   = hard_acc_reg;
        if (cmd.accum)
        begin
            // The closing particle is counted into the row, then all sums restart.
            mult_acc_next   = last_reg ? '0 : mult_upd;
            pt_acc_next     = last_reg ? '0 : pt_upd;
            energy_acc_next = last_reg ? '0 : energy_upd;
            soft_acc_next   = last_reg ? '0 : soft_upd;
            hard_acc_next   = last_reg ? '0 : hard_upd;
        end
    end

    always_comb
    begin
        out_data_next                  = out_data_reg;
        out_valid_next                 = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next                 = 1'b1;
            out_data_next.multiplicity     = COUNT_OUT_W'(mult_upd);
            out_data_next.sum_pt           = SUM_OUT_W'(pt_upd);
            out_data_next.spectator_energy = SUM_OUT_W'(energy_upd);
            out_data_next.soft_count       = COUNT_OUT_W'(soft_upd);
            out_data_next.hard_count       = COUNT_OUT_W'(hard_upd);
            out_data_next.impact_class     = (impact_reg[IMPACT_W-1] || impact_reg[IMPACT_W-2])
                                             ? CLASS_W'(2) : CLASS_W'(impact_reg[IMPACT_W-3]);
        end
    end

    // Control state: configuration, accumulators and row valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            central_tanh_sq_reg <= CENTRAL_TANH_SQ_RST;
            forward_tanh_sq_reg <= FORWARD_TANH_SQ_RST;
            soft_pt_max_reg     <= SOFT_PT_MAX_RST;
            hard_pt_min_reg     <= HARD_PT_MIN_RST;
            hard_pt_max_reg     <= HARD_PT_MAX_RST;
            mult_acc_reg        <= '0;
            pt_acc_reg          <= '0;
            energy_acc_reg      <= '0;
            soft_acc_reg        <= '0;
            hard_acc_reg        <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTRAL_TANH_SQ: central_tanh_sq_reg <= cfg_data[TANH_W-1:0];
                    CFG_FORWARD_TANH_SQ: forward_tanh_sq_reg <= cfg_data[TANH_W-1:0];
                    CFG_SOFT_PT_MAX:     soft_pt_max_reg     <= cfg_data[PT_W-1:0];
                    CFG_HARD_PT_MIN:     hard_pt_min_reg     <= cfg_data[PT_W-1:0];
                    CFG_HARD_PT_MAX:     hard_pt_max_reg     <= cfg_data[PT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            mult_acc_reg   <= mult_acc_next;
            pt_acc_reg     <= pt_acc_next;
            energy_acc_reg <= energy_acc_next;
            soft_acc_reg   <= soft_acc_next;
            hard_acc_reg   <= hard_acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (cmd.capture)
        begin
            mag_x_reg   <= mag_x;
            mag_y_reg   <= mag_y;
            mag_z_reg   <= mag_z;
            energy_reg  <= in_data.particle_energy;
            charged_reg <= in_data.is_charged;
            impact_reg  <= in_data.impact_param;
            last_reg    <= in_data.last_of_event;
        end
        if (cmd.sq_x)
        begin
            pt2_reg <= PT2_W'(sq);
        end
        if (cmd.sq_y)
        begin
            sq_reg <= sq;
        end
        if (cmd.sq_z)
        begin
            pt2_reg <= pt2_reg + PT2_W'(sq_reg);
            pz2_reg <= sq;
        end
        if (cmd.sum)
        begin
            p2_reg   <= pt2_reg + P2_W'(pz2_reg);
            rad_reg  <= pt2_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.cmul)
        begin
            prod_reg <= prod;
        end
        if (cmd.fmul)
        begin
            central_reg <= lhs < prod_reg;
            prod_reg    <= prod;
        end
        if (cmd.root_step)
        begin
            forward_reg <= lhs > prod_reg;
            rad_reg     <= rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign status.last     = last_reg;
    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

// ----- rtl/event_feature_accumulator.sv -----
// ----------------------------------------------------------------------------
// Event feature accumulator
// Per-event particle features with pseudorapidity cuts and saturating sums.
// ----------------------------------------------------------------------------
// Each accepted particle beat occupies the block from one input acceptance to
// the next: the cycle in which the beat is taken, the squares of x, y and z
// on a shared squaring multiplier, one sum, the central and forward products
// on a shared cut multiplier, a bit-serial square root for the transverse
// momentum, and one accumulation step. On the
// particle marked last of its event, a feature row is loaded into an output
// register and the accumulators restart from zero; if the previous row has not
// yet been taken, that closing particle holds in its accumulation cycle until
// it is. Rows are held in the output register while new particles are taken.
// Configuration writes apply immediately and must be made while no particle
// is in flight.
`include "event_feature_accumulator_assert.svh"

module event_feature_accumulator #(
    parameter int COUNT_WIDTH = efa_pkg::COUNT_WIDTH_DEF,
    parameter int SUM_WIDTH   = efa_pkg::SUM_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  efa_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output efa_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [efa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [efa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import efa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    efa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    efa_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // A particle keeps the block busy after its beat is taken.
    `EFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A row never appears directly after an input beat.
    `EFA_ASSERT_NEXT(a_no_row_after_accept, in_valid && in_ready, !$rose(out_valid))
    // A new row is only loaded while a particle is in flight.
    `EFA_ASSERT_NOW(a_row_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

// ----- tb/efa_result_checker.sv -----
// ----------------------------------------------------------------------------
// Event feature row checker
// Watches the particle, feature row and register ports of the accumulator,
// predicts each feature row from the accepted particle beats and compares
// every row taken from the block with the oldest predicted row.
// ----------------------------------------------------------------------------
module efa_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  efa_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  efa_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [efa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efa_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             rows_pending,
    output int                             rows_checked
);
    import efa_pkg::*;

    localparam longint unsigned COUNT_CAP = (64'd1 << COUNT_OUT_W) - 64'd1;
    localparam longint unsigned SUM_CAP   = (64'd1 << SUM_OUT_W) - 64'd1;

    logic [TANH_W-1:0] central_lim;
    logic [TANH_W-1:0] forward_lim;
    logic [PT_W-1:0]   soft_lim;
    logic [PT_W-1:0]   hard_lo;
    logic [PT_W-1:0]   hard_hi;

    longint unsigned   mult_n;
    longint unsigned   soft_n;
    longint unsigned   hard_n;
    longint unsigned   pt_running;
    longint unsigned   spectator_total;

    out_item_t         feature_rows_due[$];

    function automatic logic [MAG_W-1:0] magnitude(input logic [MOM_W-1:0] v);
        return v[MOM_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    endfunction

    // Floor square root, built one result bit at a time from the top.
    function automatic logic [PT_W-1:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = PT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[PT_W-1:0];
    endfunction

    function automatic longint unsigned add_capped(input longint unsigned acc,
                                                   input longint unsigned inc,
                                                   input longint unsigned cap);
        return (acc + inc > cap) ? cap : acc + inc;
    endfunction

    task automatic clear_sums();
        mult_n          = 0;
        soft_n          = 0;
        hard_n          = 0;
        pt_running      = 0;
        spectator_total = 0;
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH row %0d %s: got 0x%0h, expected 0x%0h",
                 rows_checked, what, got, want);
        fail_count++;
    endtask

    task automatic absorb_particle(input in_item_t p);
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [MAG_W-1:0] az;
        logic [63:0]      pt_sq;
        logic [63:0]      pz_sq;
        logic [63:0]      p_sq;
        logic [63:0]      lhs;
        logic [PT_W-1:0]  pt;
        logic [2:0]       bin;
        out_item_t        row;
        ax    = magnitude(p.mom_x);
        ay    = magnitude(p.mom_y);
        az    = magnitude(p.mom_z);
        pt_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        pz_sq = 64'(az) * 64'(az);
        p_sq  = pt_sq + pz_sq;
        // Pseudorapidity cuts compare pz^2 against tanh^2 * |p|^2 in Q0.16.
        lhs   = pz_sq << 16;
        if (p.is_charged && lhs < 64'(central_lim) * p_sq)
        begin
            pt         = floor_root(pt_sq);
            mult_n     = add_capped(mult_n, 1, COUNT_CAP);
            pt_running = add_capped(pt_running, 64'(pt), SUM_CAP);
            if (pt < soft_lim)
                soft_n = add_capped(soft_n, 1, COUNT_CAP);
            if (pt > hard_lo && pt < hard_hi)
                hard_n = add_capped(hard_n, 1, COUNT_CAP);
        end
        if (lhs > 64'(forward_lim) * p_sq)
            spectator_total = add_capped(spectator_total, 64'(p.particle_energy), SUM_CAP);
        if (p.last_of_event)
        begin
            bin                  = p.impact_param[IMPACT_W-1:9];
            row.multiplicity     = mult_n[COUNT_OUT_W-1:0];
            row.sum_pt           = pt_running[SUM_OUT_W-1:0];
            row.spectator_energy = spectator_total[SUM_OUT_W-1:0];
            row.soft_count       = soft_n[COUNT_OUT_W-1:0];
            row.hard_count       = hard_n[COUNT_OUT_W-1:0];
            row.impact_class     = (bin > 3'd2) ? 2'd2 : bin[1:0];
            feature_rows_due.push_back(row);
            clear_sums();
        end
    endtask

    task automatic check_row(input out_item_t got);
        out_item_t want;
        if (feature_rows_due.size() == 0)
        begin
            report_mismatch("row with no closed event, multiplicity", got.multiplicity, 0);
        end
        else
        begin
            want = feature_rows_due.pop_front();
            if (got.multiplicity !== want.multiplicity)
                report_mismatch("multiplicity", got.multiplicity, want.multiplicity);
            if (got.sum_pt !== want.sum_pt)
                report_mismatch("sum_pt", got.sum_pt, want.sum_pt);
            if (got.spectator_energy !== want.spectator_energy)
                report_mismatch("spectator_energy", got.spectator_energy,
                                want.spectator_energy);
            if (got.soft_count !== want.soft_count)
                report_mismatch("soft_count", got.soft_count, want.soft_count);
            if (got.hard_count !== want.hard_count)
                report_mismatch("hard_count", got.hard_count, want.hard_count);
            if (got.impact_class !== want.impact_class)
                report_mismatch("impact_class", got.impact_class, want.impact_class);
        end
        rows_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            central_lim = CENTRAL_TANH_SQ_RST;
            forward_lim = FORWARD_TANH_SQ_RST;
            soft_lim    = SOFT_PT_MAX_RST;
            hard_lo     = HARD_PT_MIN_RST;
            hard_hi     = HARD_PT_MAX_RST;
            clear_sums();
            feature_rows_due.delete();
        end
        else
        begin
            // A row leaving now always belongs to an older particle beat.
            if (out_valid && out_ready)
                check_row(out_data);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTRAL_TANH_SQ: central_lim = cfg_data[TANH_W-1:0];
                    CFG_FORWARD_TANH_SQ: forward_lim = cfg_data[TANH_W-1:0];
                    CFG_SOFT_PT_MAX:     soft_lim    = cfg_data[PT_W-1:0];
                    CFG_HARD_PT_MIN:     hard_lo     = cfg_data[PT_W-1:0];
                    CFG_HARD_PT_MAX:     hard_hi     = cfg_data[PT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                absorb_particle(in_data);
        end
        rows_pending = feature_rows_due.size();
    end

endmodule

// ----- tb/event_feature_accumulator_test.sv -----
// ----------------------------------------------------------------------------
// Event feature accumulator testbench
// Drives particle beats and register writes into the accumulator: a directed
// set of cut, window and impact class corners, and random events under
// extreme, random and reset register settings, ending with a stretch free of
// idle cycles. A separate checker predicts and compares the rows.
// ----------------------------------------------------------------------------
module event_feature_accumulator_test;
    import efa_pkg::*;

    localparam int SETTLE_CYCLES    = 40;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam int MOM_MIN = -(1 << (MOM_W - 1));
    localparam int MOM_MAX = (1 << (MOM_W - 1)) - 1;
    localparam int E_MAX   = (1 << ENERGY_W) - 1;
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int rows_pending;
    int rows_checked;
    int particles_sent;
    int settings_applied;
    int stall_cycles;
    bit idle_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    event_feature_accumulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    efa_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending),
        .rows_checked (rows_checked)
    );

    // Any cycle that moves a beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Receiver stalls: mostly short holds, now and then a long one
    // so that a closing particle has to wait for the previous row.
    initial
    begin : row_taker
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (idle_on && $urandom_range(0, 49) == 0)
                hold = $urandom_range(8, 42);
            else if (idle_on && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 7);
            out_ready <= (hold == 0);
        end
    end

    function automatic in_item_t build_particle(input int mx, input int my, input int mz,
                                                input int e, input bit chg, input int b,
                                                input bit last);
        in_item_t p;
        p.mom_x           = MOM_W'(mx);
        p.mom_y           = MOM_W'(my);
        p.mom_z           = MOM_W'(mz);
        p.particle_energy = ENERGY_W'(e);
        p.is_charged      = chg;
        p.impact_param    = IMPACT_W'(b);
        p.last_of_event   = last;
        return p;
    endfunction

    function automatic logic [MOM_W-1:0] random_momentum();
        logic [MOM_W-1:0] m;
        logic [MOM_W-1:0] raw;
        int               pick;
        pick = $urandom_range(0, 9);
        raw  = MOM_W'($urandom);
        case (pick)
            0:       m = '0;
            1:       m = MOM_W'($urandom_range(0, 3000));
            2:       m = MOM_W'($urandom_range(0, 255));
            3, 4:    m = raw;
            5:       m = raw[0] ? MOM_W'(MOM_MIN) : MOM_W'(MOM_MAX);
            default: m = MOM_W'($urandom_range(0, 65535));
        endcase
        if (pick < 3 || pick > 5)
        begin
            if ($urandom_range(0, 1) == 1)
                m = ~m + 1'b1;
        end
        return m;
    endfunction

    function automatic in_item_t random_particle(input logic [IMPACT_W-1:0] b);
        in_item_t p;
        int       pick;
        p.mom_x      = random_momentum();
        p.mom_y      = random_momentum();
        p.mom_z      = random_momentum();
        pick         = $urandom_range(0, 7);
        p.particle_energy = (pick == 0) ? ENERGY_W'(E_MAX) :
                            (pick < 3)  ? ENERGY_W'($urandom_range(0, 4095)) :
                                          ENERGY_W'($urandom);
        p.is_charged = ($urandom_range(0, 9) < 7);
        // Mostly one impact parameter per event; only the closing one counts.
        p.impact_param  = ($urandom_range(0, 9) == 0) ? IMPACT_W'($urandom) : b;
        p.last_of_event = 1'b0;
        return p;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_tanh();
        return ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 65535)) :
                                             CFG_DATA_W'($urandom_range(50000, 65535));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_pt_bound();
        return ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) :
                                             CFG_DATA_W'($urandom_range(0, 4000));
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_particle(input in_item_t p);
        int bursts;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            bursts = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
            repeat (bursts)
                repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        particles_sent++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (rows_pending != 0)
            @(negedge clk);
    endtask

    // A particle that closes no event may still be in flight after the last
    // row, so the writes wait out one more particle time as well.
    task automatic write_regs(input logic [CFG_DATA_W-1:0] central,
                              input logic [CFG_DATA_W-1:0] forward,
                              input logic [CFG_DATA_W-1:0] soft_bound,
                              input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi,
                              input bit spare);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CENTRAL_TANH_SQ;
        cfg_data  <= central;
        @(negedge clk);
        cfg_index <= CFG_FORWARD_TANH_SQ;
        cfg_data  <= forward;
        @(negedge clk);
        cfg_index <= CFG_SOFT_PT_MAX;
        cfg_data  <= soft_bound;
        @(negedge clk);
        cfg_index <= CFG_HARD_PT_MIN;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_HARD_PT_MAX;
        cfg_data  <= hi;
        @(negedge clk);
        if (spare)
        begin
            for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
            begin
                cfg_index <= CFG_IDX_W'(i);
                cfg_data  <= CFG_DATA_W'($urandom);
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_applied++;
    endtask

    task automatic run_events(input int n_items);
        int                  sent;
        int                  len;
        logic [IMPACT_W-1:0] b;
        in_item_t            p;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
                                                 $urandom_range(1, 10);
            b   = IMPACT_W'($urandom);
            for (int k = 0; k < len; k++)
            begin
                p               = random_particle(b);
                p.last_of_event = (k == len - 1);
                send_particle(p);
                sent++;
            end
            if ($urandom_range(0, 29) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] lo;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CENTRAL_TANH_SQ;
        cfg_data  = '0;
        idle_on   = 1'b1;
        particles_sent   = 0;
        settings_applied = 1;
        stall_cycles     = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Corners under the reset register values.
        send_particle(build_particle(0, 0, 0, E_MAX, 1, 0, 0));
        send_particle(build_particle(0, 0, 1000, 'h5A5A5, 0, 0, 0));
        send_particle(build_particle(0, 0, MOM_MIN, 1, 1, 0, 0));
        send_particle(build_particle(500, 0, 0, 7, 1, 0, 0));
        send_particle(build_particle(818, 0, 0, 0, 1, 0, 0));
        send_particle(build_particle(819, 0, 0, 0, 1, 0, 0));
        send_particle(build_particle(2000, -300, 0, 0, 1, 0, 0));
        send_particle(build_particle(1638, 0, 0, 0, 1, 0, 0));
        send_particle(build_particle(1639, 0, 0, 0, 1, 0, 0));
        send_particle(build_particle(0, -2457, 0, 0, 1, 0, 0));
        send_particle(build_particle(2458, 0, 0, 0, 1, 0, 0));
        send_particle(build_particle(1500, 0, 0, 99, 0, 0, 0));
        send_particle(build_particle(1000, 0, 3000, 0, 1, 0, 0));
        send_particle(build_particle(1000, 0, -5000, 0, 1, 0, 0));
        send_particle(build_particle(MOM_MIN, MOM_MIN, 0, 0, 1, 0, 0));
        send_particle(build_particle(MOM_MAX, MOM_MAX, MOM_MAX, 0, 1, 4095, 1));
        send_particle(build_particle(-1, -1, -1, 3, 1, 511, 1));
        send_particle(build_particle(0, 0, 77, 5, 0, 512, 1));
        send_particle(build_particle(300, 0, 0, 0, 1, 1023, 1));
        send_particle(build_particle(0, 0, 0, 0, 0, 1024, 1));
        send_particle(build_particle(0, 0, 0, 0, 1, 1535, 1));
        send_particle(build_particle(0, 0, 0, 0, 0, 0, 1));
        // The sender waits here until every row is out before going on.
        hold_until_drained();
        run_events(RANDOM_PER_PHASE);

        // Nothing central, everything with pz forward, empty windows.
        write_regs('0, '0, '0, CFG_ALL_ONES, '0, 1'b0);
        run_events(RANDOM_PER_PHASE);

        // Widest central cut and windows; data bits above register width set.
        write_regs(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, '0, CFG_ALL_ONES, 1'b1);
        run_events(RANDOM_PER_PHASE);

        repeat (3)
        begin
            write_regs(random_tanh(), random_tanh(), random_pt_bound(),
                       random_pt_bound(), random_pt_bound(), 1'b1);
            run_events(RANDOM_PER_PHASE / 3);
        end

        // Hard windows whose lower bound is not below the upper one.
        lo = random_pt_bound();
        write_regs(random_tanh(), random_tanh(), random_pt_bound(), lo, lo, 1'b0);
        run_events(RANDOM_PER_PHASE / 2);
        lo = random_pt_bound();
        write_regs(random_tanh(), random_tanh(), random_pt_bound(), lo,
                   CFG_DATA_W'($urandom_range(0, lo)), 1'b0);
        run_events(RANDOM_PER_PHASE / 2);

        // The last stretch runs with no idle cycles on either side.
        idle_on = 1'b0;
        write_regs(CFG_DATA_W'(CENTRAL_TANH_SQ_RST), CFG_DATA_W'(FORWARD_TANH_SQ_RST),
                   CFG_DATA_W'(SOFT_PT_MAX_RST), CFG_DATA_W'(HARD_PT_MIN_RST),
                   CFG_DATA_W'(HARD_PT_MAX_RST), 1'b0);
        run_events(RANDOM_PER_PHASE);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d particle beats, checked %0d feature rows under %0d register settings,",
                 particles_sent, rows_checked, settings_applied);
        $display("covering cut and window corners, impact classes and inverted hard windows.");
        if (fail_count == 0 && rows_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
